// ===== hdl/lzwc_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared constants and the dictionary entry layout.
// ----------------------------------------------------------------------------
`default_nettype none
package lzwc_pkg;
	localparam int HASH_SIZE_DEF = 5021;
	localparam int FULL_CODE_DEF = 4094;
	localparam int CODE_W = 12;
	localparam int WIDTH_W = 4;
	localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
	localparam logic [CODE_W-1:0] CODE_EOD = 12'd257;
	localparam logic [CODE_W-1:0] CODE_FIRST = 12'd258;
	localparam logic [WIDTH_W-1:0] WIDTH_START = 4'd9;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 4'd12;
	localparam logic [CODE_W-1:0] WIDEN_START = 12'd511;

	typedef struct packed {
		logic valid;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] base;
		logic [7:0] ch;
	} dict_entry_t;

	localparam int ENTRY_W = $bits(dict_entry_t);
endpackage
`default_nettype wire

// ===== hdl/lzwc_ram.sv =====
// ----------------------------------------------------------------------------
// LZW compressor RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/lzw_byte_compressor.sv =====
// ----------------------------------------------------------------------------
// LZW byte compressor
// 12-bit LZW with early change, double-hashed dictionary in one RAM,
// MSB-first packed code bytes out.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata          tlast        tuser
// s_*      in   data_byte      end_of_data  -
// m_*      out  out_byte       run_last     stream_last
//
// Each byte is accepted, then the dictionary is probed (RAM read and compare
// per probe), bookkeeping follows (with a decide step on a miss), each queued
// code is loaded and shifted out one byte at a time, and a pad byte may follow.
// The next byte is accepted only when this is done. After reset, after every
// dictionary clear and every stream end, a clearing pass runs with s_tready low.
// A stall on m_tready holds the packer; the output register lets work go on.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_byte_compressor #(
	parameter int HASH_SIZE = lzwc_pkg::HASH_SIZE_DEF,
	parameter int FULL_CODE = lzwc_pkg::FULL_CODE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,   // [7:0] data_byte
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata,       // [7:0] out_byte
	output logic m_tlast,
	output logic m_tuser               // [0] stream_last
);
	import lzwc_pkg::*;

	localparam int IW = $clog2(HASH_SIZE);
	localparam int NW = $clog2(HASH_SIZE + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(HASH_SIZE - 1);
	localparam logic [NW-1:0] LAST_PROBE = NW'(HASH_SIZE - 1);
	localparam logic [IW:0] HASH_N = (IW+1)'(HASH_SIZE);
	localparam logic [CODE_W-1:0] FULL_C = CODE_W'(FULL_CODE);
	localparam int AW = 19;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_CMP = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_TAIL = 4'd4;
	localparam logic [3:0] S_LOAD = 4'd5;
	localparam logic [3:0] S_EMIT = 4'd6;
	localparam logic [3:0] S_PAD = 4'd7;
	localparam logic [3:0] S_FIN = 4'd8;
	localparam logic [3:0] S_SWEEP = 4'd9;

	logic [3:0] state_q;
	logic [IW-1:0] sweep_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] step_q;
	logic [NW-1:0] probe_q;
	logic [7:0] ch_q;
	logic last_q;
	logic exh_q;
	logic clr_q;
	logic pad_q;
	logic started_q;
	logic [CODE_W-1:0] prefix_q;
	logic [CODE_W-1:0] nfc_q;
	logic [WIDTH_W-1:0] w_q;
	logic [CODE_W-1:0] wp_q;
	logic [AW-1:0] acc_q;
	logic [4:0] cnt_q;
	logic [31:0] taken_q;
	logic [31:0] given_q;
	logic [CODE_W-1:0] q_code_q [0:3];
	logic [WIDTH_W-1:0] q_w_q [0:3];
	logic [2:0] qn_q;
	logic [2:0] qi_q;

	logic m_valid_q;
	logic [7:0] m_data_q;
	logic m_last_q;
	logic m_user_q;

	logic ram_we;
	logic [IW-1:0] ram_waddr;
	dict_entry_t ram_wdata;
	dict_entry_t ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	logic [IW-1:0] hash_i;
	logic [IW:0] probe_sum;
	logic [IW-1:0] probe_next;
	logic widen;
	logic [WIDTH_W-1:0] w_up;
	logic [4:0] nb_prefix;
	logic [32:0] given_sum;
	logic [31:0] given_p;
	logic [32:0] eff_lim;
	logic eff;
	logic clr_c;
	logic slot_free;
	logic out_load;
	logic [AW-1:0] pend;
	logic [CODE_W-1:0] ld_code;
	logic [WIDTH_W-1:0] ld_w;
	logic [AW-1:0] ld_acc;
	logic [4:0] cnt_dn;
	logic [7:0] emit_byte;
	logic emit_last;
	logic [7:0] pad_byte;

	assign ram_rdata = dict_entry_t'(ram_rbits);

	lzwc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HASH_SIZE)
	) u_dict (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rbits)
	);

	always_comb begin
		hash_i = IW'({s_tdata, 4'b0000} ^ prefix_q);
		probe_sum = {1'b0, idx_q} + {1'b0, step_q};
		probe_next = (probe_sum >= HASH_N) ? IW'(probe_sum - HASH_N) : probe_sum[IW-1:0];

		widen = (nfc_q == wp_q) && (w_q < WIDTH_MAX);
		w_up = w_q + 4'd1;
		nb_prefix = (cnt_q + 5'(w_q)) >> 3;
		given_sum = {1'b0, given_q} + 33'(nb_prefix);
		given_p = given_sum[32] ? 32'hFFFF_FFFF : given_sum[31:0];
		eff_lim = {1'b0, taken_q} + 33'(taken_q >> 4);
		eff = widen && ({1'b0, given_p} > eff_lim);
		clr_c = exh_q || eff || (nfc_q >= FULL_C);

		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata.valid = 1'b1;
		ram_wdata.code = nfc_q;
		ram_wdata.base = prefix_q;
		ram_wdata.ch = ch_q;
		if (state_q == S_SWEEP) begin
			ram_we = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '0;
		end else if (state_q == S_DECIDE) begin
			ram_we = !clr_c;
		end

		slot_free = !m_valid_q || m_tready;
		out_load = slot_free && (((state_q == S_EMIT) && (cnt_q >= 5'd8)) ||
			(state_q == S_PAD));
		pend = acc_q & ((AW'(1) << cnt_q) - AW'(1));
		ld_code = q_code_q[qi_q[1:0]];
		ld_w = q_w_q[qi_q[1:0]];
		ld_acc = (pend << ld_w) | AW'(ld_code & ((CODE_W'(1) << ld_w) - CODE_W'(1)));
		cnt_dn = cnt_q - 5'd8;
		emit_byte = 8'(acc_q >> cnt_dn);
		emit_last = (cnt_dn < 5'd8) && (qi_q == qn_q) && !(pad_q && (cnt_dn != 5'd0));
		pad_byte = 8'(pend << (5'd8 - cnt_q));
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tlast = m_last_q;
	assign m_tuser = m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_q <= '0;
			started_q <= 1'b0;
			prefix_q <= '0;
			nfc_q <= CODE_FIRST;
			w_q <= WIDTH_START;
			wp_q <= WIDEN_START;
			acc_q <= '0;
			cnt_q <= '0;
			taken_q <= '0;
			given_q <= '0;
			qn_q <= '0;
			qi_q <= '0;
			last_q <= 1'b0;
			exh_q <= 1'b0;
			clr_q <= 1'b0;
			pad_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ch_q <= s_tdata;
						last_q <= s_tlast;
						exh_q <= 1'b0;
						clr_q <= 1'b0;
						pad_q <= 1'b0;
						qi_q <= '0;
						if (taken_q != 32'hFFFF_FFFF) begin
							taken_q <= taken_q + 32'd1;
						end
						if (!started_q) begin
							started_q <= 1'b1;
							prefix_q <= {4'd0, s_tdata};
							q_code_q[0] <= CODE_CLEAR;
							q_w_q[0] <= w_q;
							qn_q <= 3'd1;
							state_q <= S_TAIL;
						end else begin
							qn_q <= '0;
							idx_q <= hash_i;
							step_q <= (hash_i == '0) ? IW'(1) : IW'(HASH_N - {1'b0, hash_i});
							probe_q <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!ram_rdata.valid) begin
						state_q <= S_DECIDE;
					end else if (ram_rdata.base == prefix_q && ram_rdata.ch == ch_q) begin
						prefix_q <= ram_rdata.code;
						state_q <= S_TAIL;
					end else if (probe_q == LAST_PROBE) begin
						exh_q <= 1'b1;
						state_q <= S_DECIDE;
					end else begin
						idx_q <= probe_next;
						probe_q <= probe_q + NW'(1);
						state_q <= S_RD;
					end
				end
				S_DECIDE: begin
					q_code_q[0] <= prefix_q;
					q_w_q[0] <= w_q;
					if (clr_c) begin
						q_code_q[1] <= CODE_CLEAR;
						q_w_q[1] <= widen ? w_up : w_q;
						qn_q <= 3'd2;
						clr_q <= 1'b1;
						nfc_q <= CODE_FIRST;
						w_q <= WIDTH_START;
						wp_q <= WIDEN_START;
					end else begin
						qn_q <= 3'd1;
						if (widen) begin
							w_q <= w_up;
							wp_q <= CODE_W'((13'd1 << w_up) - 13'd1);
						end
						nfc_q <= nfc_q + CODE_W'(1);
					end
					prefix_q <= {4'd0, ch_q};
					state_q <= S_TAIL;
				end
				S_TAIL: begin
					if (last_q) begin
						q_code_q[qn_q[1:0]] <= prefix_q;
						q_w_q[qn_q[1:0]] <= w_q;
						q_code_q[qn_q[1:0] + 2'd1] <= CODE_EOD;
						q_w_q[qn_q[1:0] + 2'd1] <= w_q;
						qn_q <= qn_q + 3'd2;
						pad_q <= 1'b1;
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (qi_q == qn_q) begin
						state_q <= (pad_q && cnt_q != 5'd0) ? S_PAD : S_FIN;
					end else begin
						acc_q <= ld_acc;
						cnt_q <= cnt_q + 5'(ld_w);
						qi_q <= qi_q + 3'd1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (cnt_q < 5'd8) begin
						state_q <= S_LOAD;
					end else if (slot_free) begin
						m_data_q <= emit_byte;
						m_last_q <= emit_last;
						m_user_q <= emit_last && last_q;
						cnt_q <= cnt_dn;
						if (given_q != 32'hFFFF_FFFF) begin
							given_q <= given_q + 32'd1;
						end
					end
				end
				S_PAD: begin
					if (slot_free) begin
						m_data_q <= pad_byte;
						m_last_q <= 1'b1;
						m_user_q <= 1'b1;
						cnt_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (last_q) begin
						started_q <= 1'b0;
						prefix_q <= '0;
						nfc_q <= CODE_FIRST;
						w_q <= WIDTH_START;
						wp_q <= WIDEN_START;
						cnt_q <= '0;
						taken_q <= '0;
						given_q <= '0;
						sweep_q <= '0;
						state_q <= S_SWEEP;
					end else if (clr_q) begin
						taken_q <= '0;
						given_q <= '0;
						sweep_q <= '0;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (sweep_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// LZW byte compressor testbench
// Streams of bytes go in through the slave port with random gaps. An encoder
// model in this file predicts the packed code bytes of every transfer, and
// each output transfer is compared with the oldest predicted byte. Short
// streams, streams with repeated strings and one longer random stream are
// sent.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lzwc_pkg::*;

	localparam int HSIZE = HASH_SIZE_DEF;

	typedef struct {
		logic [7:0] data;
		logic       last;
		int         gap;
		bit         drain;
	} in_item_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_last;
	} code_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	in_item_t   byte_queue[$];
	code_byte_t packed_expect[$];
	int         errors = 0;
	bit         in_fire = 0;
	bit         out_fire = 0;

	// Encoder model state.
	bit          dict_used[HSIZE];
	logic [11:0] dict_code[HSIZE];
	logic [11:0] dict_base[HSIZE];
	logic [7:0]  dict_ch[HSIZE];
	logic [11:0] cur_prefix;
	bit          in_stream;
	logic [11:0] free_code;
	logic [3:0]  width;
	logic [11:0] widen_at;
	logic [6:0]  bit_store;
	logic [2:0]  bit_count;
	logic [31:0] taken_cnt;
	logic [31:0] given_cnt;
	logic [7:0]  step_bytes[16];
	int          step_count;

	lzw_byte_compressor u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic empty_dictionary();
		for (int i = 0; i < HSIZE; i++) dict_used[i] = 0;
		free_code = CODE_FIRST;
		width = WIDTH_START;
		widen_at = WIDEN_START;
	endtask

	task automatic encoder_reset();
		empty_dictionary();
		cur_prefix = '0;
		in_stream = 0;
		bit_store = '0;
		bit_count = '0;
		taken_cnt = '0;
		given_cnt = '0;
	endtask

	task automatic emit_code(input logic [11:0] code, input logic [3:0] w);
		logic [31:0] acc;
		int cnt;
		acc = ({25'd0, bit_store} << w) | (32'(code) & ((32'd1 << w) - 1));
		cnt = bit_count + w;
		while (cnt >= 8) begin
			if (step_count < 16) begin
				step_bytes[step_count] = 8'(acc >> (cnt - 8));
				step_count++;
			end
			if (given_cnt != 32'hFFFF_FFFF) given_cnt++;
			cnt -= 8;
		end
		bit_store = 7'(acc & ((32'd1 << cnt) - 1));
		bit_count = 3'(cnt);
	endtask

	function automatic int probe_slot(input logic [11:0] code, input logic [7:0] ch);
		int i, stp;
		i = ((int'(ch) << 4) ^ int'(code)) % HSIZE;
		stp = (i == 0) ? 1 : HSIZE - i;
		for (int n = 0; n < HSIZE; n++) begin
			if (!dict_used[i]) return i;
			if (dict_base[i] == code && dict_ch[i] == ch) return i;
			i += stp;
			if (i >= HSIZE) i -= HSIZE;
		end
		return -1;
	endfunction

	task automatic encode_byte(input logic [7:0] ch, input logic last);
		int slot;
		bit do_clear;
		logic [32:0] limit;
		code_byte_t cb;
		step_count = 0;
		if (taken_cnt != 32'hFFFF_FFFF) taken_cnt++;
		if (!in_stream) begin
			in_stream = 1;
			cur_prefix = {4'd0, ch};
			emit_code(CODE_CLEAR, width);
		end else begin
			slot = probe_slot(cur_prefix, ch);
			if (slot >= 0 && dict_used[slot]) begin
				cur_prefix = dict_code[slot];
			end else begin
				do_clear = (slot < 0);
				emit_code(cur_prefix, width);
				if (free_code == widen_at && width < WIDTH_MAX) begin
					width++;
					widen_at = 12'((13'd1 << width) - 1);
					limit = {1'b0, taken_cnt} + {5'd0, taken_cnt[31:4]};
					if ({1'b0, given_cnt} > limit) do_clear = 1;
				end
				if (do_clear || free_code >= 12'(FULL_CODE_DEF)) begin
					emit_code(CODE_CLEAR, width);
					empty_dictionary();
					taken_cnt = '0;
					given_cnt = '0;
				end else begin
					dict_used[slot] = 1;
					dict_code[slot] = free_code;
					dict_base[slot] = cur_prefix;
					dict_ch[slot] = ch;
					free_code = free_code + 12'd1;
				end
				cur_prefix = {4'd0, ch};
			end
		end
		if (last) begin
			emit_code(cur_prefix, width);
			emit_code(CODE_EOD, width);
			if (bit_count > 0 && step_count < 16) begin
				step_bytes[step_count] = 8'({1'b0, bit_store} << (8 - bit_count));
				step_count++;
			end
		end
		if (step_count > 7) step_count = 7;
		for (int k = 0; k < step_count; k++) begin
			cb.out_byte = step_bytes[k];
			cb.run_last = (k == step_count - 1);
			cb.stream_last = (k == step_count - 1) && last;
			packed_expect.push_back(cb);
		end
		if (last) encoder_reset();
	endtask

	always @(posedge clk) begin
		code_byte_t want;
		in_fire = s_tvalid && s_tready;
		out_fire = m_tvalid && m_tready;
		if (in_fire) encode_byte(s_tdata, s_tlast);
		if (out_fire) begin
			if (packed_expect.size() == 0) begin
				$display("%0t: unexpected transfer out_byte=%h last=%b user=%b",
					$time, m_tdata, m_tlast, m_tuser);
				errors++;
			end else begin
				want = packed_expect.pop_front();
				if (m_tdata !== want.out_byte || m_tlast !== want.run_last ||
						m_tuser !== want.stream_last) begin
					$display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
						want.out_byte, want.run_last, want.stream_last,
						m_tdata, m_tlast, m_tuser);
					errors++;
				end
			end
		end
	end

	int wait_cnt = 0;
	always @(negedge clk) begin
		logic nv;
		nv = s_tvalid && !in_fire;
		if (!nv && arst_n && byte_queue.size() > 0) begin
			if (byte_queue[0].drain && packed_expect.size() != 0) begin
				wait_cnt = 0;
			end else if (wait_cnt < byte_queue[0].gap) begin
				wait_cnt++;
			end else begin
				s_tdata <= byte_queue[0].data;
				s_tlast <= byte_queue[0].last;
				void'(byte_queue.pop_front());
				wait_cnt = 0;
				nv = 1;
			end
		end
		s_tvalid <= nv;
	end

	int stall = 0;
	bit no_stall = 0;
	int stall_items = 0;
	always @(negedge clk) begin
		if (out_fire || !arst_n) begin
			stall_items++;
			if (stall_items % 40 == 0) no_stall = !no_stall;
			stall = no_stall ? 0 : $urandom_range(0, 7);
		end
		if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	bit burst = 0;
	task automatic add_byte(input logic [7:0] d, input logic l, input bit drain = 0);
		in_item_t it;
		it.data = d;
		it.last = l;
		it.gap = burst ? 0 : $urandom_range(0, 7);
		it.drain = drain;
		byte_queue.push_back(it);
	endtask

	task automatic add_stream(input int len, input int alphabet);
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom_range(0, alphabet - 1) * (alphabet < 256 ? 37 : 1)),
				i == len - 1);
	endtask

	initial begin
		encoder_reset();
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		for (int i = 0; i < 10; i++) add_byte(i % 2 ? 8'h42 : 8'h41, i == 9);
		for (int i = 0; i < 8; i++) add_byte(8'hAA, i == 7);
		for (int i = 0; i < 4; i++) add_byte(8'h55 ^ 8'(i), i == 3);
		for (int s = 0; s < 10; s++) begin
			burst = (s % 4 == 3);
			add_stream($urandom_range(1, 12), ($urandom_range(0, 1) != 0) ? 3 : 256);
			if (s == 6) byte_queue[byte_queue.size() - 1].drain = 1;
		end
		burst = 0;
		add_byte(8'h12, 1'b0, 1);
		add_stream(56, 256);
		for (int s = 0; s < 4; s++) add_stream($urandom_range(1, 10), 256);
		wait (byte_queue.size() == 0 && !s_tvalid);
		wait (packed_expect.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && packed_expect.size() == 0) begin
			$display("lzw_byte_compressor verification clean");
		end else begin
			$display("lzw_byte_compressor verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("lzw_byte_compressor verification failed");
		$finish;
	end
endmodule

// ===== lzw_byte_compressor.f =====
hdl/lzwc_pkg.sv
hdl/lzwc_ram.sv
hdl/lzw_byte_compressor.sv
test/tb_top.sv
